FILE: rtl/cmr_pkg.sv
// ----------------------------------------------------------------------------
// cmr_pkg
// Shared types, constants and result codes of the message reassembly block.
// ----------------------------------------------------------------------------
package cmr_pkg;

  // Default sizes
  localparam int unsigned SLOTS_DEF     = 4;
  localparam int unsigned MAX_SEGS_DEF  = 8;
  localparam int unsigned SEG_BYTES_DEF = 512;
  localparam int unsigned MSG_CAP_DEF   = 1024;

  // Result status codes
  localparam logic [2:0] ST_STORED      = 3'd0;
  localparam logic [2:0] ST_SEG_DONE    = 3'd1;
  localparam logic [2:0] ST_MSG_DONE    = 3'd2;
  localparam logic [2:0] ST_PASS        = 3'd3;
  localparam logic [2:0] ST_SEG_LONG    = 3'd4;
  localparam logic [2:0] ST_DRAIN_BYTE  = 3'd5;
  localparam logic [2:0] ST_DRAIN_EMPTY = 3'd6;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SUM_RD,
    S_SUM_ACC,
    S_SUM_FIN,
    S_DR_TEST,
    S_DR_CHK,
    S_DR_BYTE
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic cap;      // latch the accepted word
    logic seg_go;   // execute a segment byte
    logic sum_rd;   // steer the length read port to the summation
    logic sum_acc;  // add one segment length
    logic sum_fin;  // cap the sum, emit message complete
    logic dr_pick;  // start or continue a drain
    logic dr_test;  // drain found exhausted: free slot, emit empty
    logic dr_chk;   // step over a finished segment
    logic dr_byte;  // emit one drained byte
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic op;
    logic seg_sum;
    logic pick_hit;
    logic dr_empty;
    logic chk_hit;
    logic sum_last;
    logic out_free;
  } sts_t;

endpackage

FILE: rtl/cmr_ctrl.sv
// ----------------------------------------------------------------------------
// cmr_ctrl
// Sequencer: steps one word at a time through segment, sum and drain phases.
// ----------------------------------------------------------------------------
module cmr_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  cmr_pkg::sts_t  sts_i,
  output cmr_pkg::cmd_t  cmd_o
);

  cmr_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cmr_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      cmr_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.cap = 1'b1;
          state_d   = cmr_pkg::S_EXEC;
        end
      end
      cmr_pkg::S_EXEC: begin
        if (sts_i.out_free) begin
          if (sts_i.op) begin
            cmd_o.dr_pick = 1'b1;
            state_d = sts_i.pick_hit ? cmr_pkg::S_DR_TEST : cmr_pkg::S_IDLE;
          end else begin
            cmd_o.seg_go = 1'b1;
            state_d = sts_i.seg_sum ? cmr_pkg::S_SUM_RD : cmr_pkg::S_IDLE;
          end
        end
      end
      cmr_pkg::S_SUM_RD: begin
        cmd_o.sum_rd = 1'b1;
        state_d      = cmr_pkg::S_SUM_ACC;
      end
      cmr_pkg::S_SUM_ACC: begin
        cmd_o.sum_acc = 1'b1;
        state_d = sts_i.sum_last ? cmr_pkg::S_SUM_FIN : cmr_pkg::S_SUM_RD;
      end
      cmr_pkg::S_SUM_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.sum_fin = 1'b1;
          state_d       = cmr_pkg::S_IDLE;
        end
      end
      cmr_pkg::S_DR_TEST: begin
        if (!sts_i.dr_empty) begin
          state_d = cmr_pkg::S_DR_CHK;
        end else if (sts_i.out_free) begin
          cmd_o.dr_test = 1'b1;
          state_d       = cmr_pkg::S_IDLE;
        end
      end
      cmr_pkg::S_DR_CHK: begin
        cmd_o.dr_chk = 1'b1;
        state_d = sts_i.chk_hit ? cmr_pkg::S_DR_BYTE : cmr_pkg::S_DR_TEST;
      end
      cmr_pkg::S_DR_BYTE: begin
        if (sts_i.out_free) begin
          cmd_o.dr_byte = 1'b1;
          state_d       = cmr_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = cmr_pkg::S_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/cmr_dpath.sv
// ----------------------------------------------------------------------------
// cmr_dpath
// Slot tables, segment context, length and byte stores, drain pointer and
// the result register.
// ----------------------------------------------------------------------------
module cmr_dpath #(
  parameter int unsigned SLOTS     = cmr_pkg::SLOTS_DEF,
  parameter int unsigned MAX_SEGS  = cmr_pkg::MAX_SEGS_DEF,
  parameter int unsigned SEG_BYTES = cmr_pkg::SEG_BYTES_DEF,
  parameter int unsigned MSG_CAP   = cmr_pkg::MSG_CAP_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  cmr_pkg::cmd_t  cmd_i,
  output cmr_pkg::sts_t  sts_o,
  input  logic           op_i,
  input  logic [15:0]    msg_ref_i,
  input  logic [7:0]     msg_total_i,
  input  logic [7:0]     seg_number_i,
  input  logic [7:0]     data_in_i,
  input  logic           seg_last_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [2:0]     status_o,
  output logic [7:0]     data_out_o,
  output logic [1:0]     slot_o,
  output logic [9:0]     total_length_o,
  output logic           drain_last_o
);

  localparam int unsigned SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned KW    = (MAX_SEGS > 1) ? $clog2(MAX_SEGS) : 1;
  localparam int unsigned JW    = $clog2(MAX_SEGS + 1);
  localparam int unsigned CW    = $clog2(SEG_BYTES + 1);
  localparam int unsigned ROWS  = SLOTS * MAX_SEGS;
  localparam int unsigned LAW   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned BAW   = $clog2(ROWS * SEG_BYTES);
  localparam int unsigned TW    = $clog2(MSG_CAP);
  localparam int unsigned SUMW  = $clog2(MAX_SEGS * SEG_BYTES + 1);

  // Latched word
  logic        op_q, last_q;
  logic [15:0] ref_q;
  logic [7:0]  tot_q, sn_q, din_q;

  // Slot tables
  logic [15:0]         sref_q  [SLOTS];
  logic [7:0]          stot_q  [SLOTS];
  logic [MAX_SEGS-1:0] valid_q [SLOTS];
  logic [SLOTS-1:0]    ready_q;
  logic [TW-1:0]       mlen_q  [SLOTS];

  // Open segment
  logic          ctx_open_q, ctx_ovl_q;
  logic [SW-1:0] ctx_slot_q;
  logic [KW-1:0] ctx_seg_q;
  logic [CW-1:0] ctx_cnt_q;

  // Drain pointer
  logic          dr_active_q;
  logic [SW-1:0] dr_slot_q;
  logic [TW-1:0] dr_pos_q;
  logic [KW-1:0] dr_k_q;
  logic [CW-1:0] dr_off_q;

  // Summation
  logic [SW-1:0]   sum_slot_q;
  logic [JW-1:0]   sum_j_q;
  logic [SUMW-1:0] sum_q;

  // Stores
  logic [CW-1:0] len_mem  [ROWS];
  logic [7:0]    byte_mem [ROWS * SEG_BYTES];
  logic [CW-1:0] len_rd_q;
  logic [7:0]    byte_rd_q;

  // Result register
  logic       ovalid_q;
  logic [2:0] ost_q;
  logic [7:0] odata_q;
  logic [1:0] oslot_q;
  logic [9:0] olen_q;
  logic       olast_q;

  logic                hit_m, hit_f, hdr_bad, pass, claim, reopen, store;
  logic                ovl_nx, allv, pick_any, dr_last, out_free;
  logic [SW-1:0]       m_idx, f_idx, s_sel, pick_idx;
  logic [KW-1:0]       k_idx;
  logic [CW-1:0]       cnt_cur, cnt_nx;
  logic [MAX_SEGS-1:0] vcur, vfin;
  logic [TW-1:0]       t_cur, pos_nx, t_cap;
  logic [LAW-1:0]      wrow, len_raddr, dr_row;
  logic [BAW-1:0]      byte_waddr, byte_raddr;
  logic                len_we, byte_we;

  always_comb begin
    hit_m = 1'b0;
    m_idx = '0;
    hit_f = 1'b0;
    f_idx = '0;
    pick_any = 1'b0;
    pick_idx = '0;
    for (int s = SLOTS - 1; s >= 0; s--) begin
      if (stot_q[s] != 8'd0 && sref_q[s] == ref_q && stot_q[s] == tot_q) begin
        hit_m = 1'b1;
        m_idx = SW'(s);
      end
      if (stot_q[s] == 8'd0) begin
        hit_f = 1'b1;
        f_idx = SW'(s);
      end
      if (ready_q[s]) begin
        pick_any = 1'b1;
        pick_idx = SW'(s);
      end
    end

    hdr_bad = (tot_q == 8'd0) || (32'(tot_q) > MAX_SEGS) ||
              (sn_q == 8'd0) || (sn_q > tot_q);
    claim   = !hit_m;
    s_sel   = hit_m ? m_idx : f_idx;
    pass    = hdr_bad || (!hit_m && !hit_f) || (hit_m && ready_q[m_idx]);
    k_idx   = KW'(sn_q - 8'd1);
    reopen  = !(ctx_open_q && ctx_slot_q == s_sel && ctx_seg_q == k_idx);
    cnt_cur = reopen ? '0 : ctx_cnt_q;
    store   = cnt_cur < CW'(SEG_BYTES);
    cnt_nx  = store ? cnt_cur + CW'(1) : cnt_cur;
    ovl_nx  = (reopen ? 1'b0 : ctx_ovl_q) | !store;

    vcur = claim ? '0 : valid_q[s_sel];
    if (reopen) begin
      vcur[k_idx] = 1'b0;
    end
    vfin = vcur;
    vfin[k_idx] = 1'b1;
    allv = 1'b1;
    for (int i = 0; i < MAX_SEGS; i++) begin
      if (8'(i) < tot_q && !vfin[i]) begin
        allv = 1'b0;
      end
    end

    t_cur   = mlen_q[dr_slot_q];
    pos_nx  = dr_pos_q + TW'(1);
    dr_last = pos_nx >= t_cur;
    t_cap   = (32'(sum_q) >= MSG_CAP) ? TW'(MSG_CAP - 1) : TW'(sum_q);

    wrow       = LAW'(s_sel) * LAW'(MAX_SEGS) + LAW'(k_idx);
    dr_row     = LAW'(dr_slot_q) * LAW'(MAX_SEGS) + LAW'(dr_k_q);
    len_raddr  = cmd_i.sum_rd ? LAW'(sum_slot_q) * LAW'(MAX_SEGS) + LAW'(sum_j_q)
                              : dr_row;
    byte_waddr = BAW'(wrow) * BAW'(SEG_BYTES) + BAW'(cnt_cur);
    byte_raddr = BAW'(dr_row) * BAW'(SEG_BYTES) + BAW'(dr_off_q);
    len_we     = cmd_i.seg_go && !pass && last_q && !ovl_nx;
    byte_we    = cmd_i.seg_go && !pass && store;

    out_free = !ovalid_q || out_ready_i;
  end

  assign sts_o.op       = op_q;
  assign sts_o.seg_sum  = !pass && last_q && !ovl_nx && allv;
  assign sts_o.pick_hit = dr_active_q || pick_any;
  assign sts_o.dr_empty = dr_pos_q >= t_cur;
  assign sts_o.chk_hit  = dr_off_q < len_rd_q;
  assign sts_o.sum_last = (9'(sum_j_q) + 9'd1) == {1'b0, tot_q};
  assign sts_o.out_free = out_free;

  // Stores
  always_ff @(posedge clk_i) begin
    if (len_we) begin
      len_mem[wrow] <= cnt_nx;
    end
    len_rd_q <= len_mem[len_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (byte_we) begin
      byte_mem[byte_waddr] <= din_q;
    end
    byte_rd_q <= byte_mem[byte_raddr];
  end

  // Latched word
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      op_q   <= op_i;
      ref_q  <= msg_ref_i;
      tot_q  <= msg_total_i;
      sn_q   <= seg_number_i;
      din_q  <= data_in_i;
      last_q <= seg_last_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < SLOTS; s++) begin
        sref_q[s]  <= '0;
        stot_q[s]  <= '0;
        valid_q[s] <= '0;
        mlen_q[s]  <= '0;
      end
      ready_q     <= '0;
      ctx_open_q  <= 1'b0;
      ctx_ovl_q   <= 1'b0;
      ctx_slot_q  <= '0;
      ctx_seg_q   <= '0;
      ctx_cnt_q   <= '0;
      dr_active_q <= 1'b0;
      dr_slot_q   <= '0;
      dr_pos_q    <= '0;
      dr_k_q      <= '0;
      dr_off_q    <= '0;
      sum_slot_q  <= '0;
      sum_j_q     <= '0;
      sum_q       <= '0;
      ovalid_q    <= 1'b0;
      ost_q       <= '0;
      odata_q     <= '0;
      oslot_q     <= '0;
      olen_q      <= '0;
      olast_q     <= 1'b0;
    end else begin
      if (ovalid_q && out_ready_i) begin
        ovalid_q <= 1'b0;
      end

      if (cmd_i.seg_go) begin
        ovalid_q <= 1'b1;
        odata_q  <= '0;
        oslot_q  <= 2'(s_sel);
        olen_q   <= '0;
        olast_q  <= 1'b0;
        if (pass) begin
          ost_q   <= cmr_pkg::ST_PASS;
          odata_q <= din_q;
          oslot_q <= '0;
        end else begin
          if (claim) begin
            sref_q[s_sel] <= ref_q;
            stot_q[s_sel] <= tot_q;
          end
          ctx_open_q <= !last_q;
          ctx_slot_q <= s_sel;
          ctx_seg_q  <= k_idx;
          ctx_cnt_q  <= cnt_nx;
          ctx_ovl_q  <= ovl_nx;
          valid_q[s_sel] <= (last_q && !ovl_nx) ? vfin : vcur;
          if (ovl_nx) begin
            ost_q   <= cmr_pkg::ST_SEG_LONG;
            odata_q <= din_q;
          end else if (!last_q) begin
            ost_q <= cmr_pkg::ST_STORED;
          end else if (!allv) begin
            ost_q <= cmr_pkg::ST_SEG_DONE;
          end else begin
            // hold the result until the length sum is done
            ovalid_q       <= 1'b0;
            ready_q[s_sel] <= 1'b1;
            sum_slot_q     <= s_sel;
            sum_j_q        <= '0;
            sum_q          <= '0;
          end
        end
      end

      if (cmd_i.sum_acc) begin
        sum_q   <= sum_q + SUMW'(len_rd_q);
        sum_j_q <= sum_j_q + JW'(1);
      end

      if (cmd_i.sum_fin) begin
        mlen_q[sum_slot_q] <= t_cap;
        ovalid_q <= 1'b1;
        ost_q    <= cmr_pkg::ST_MSG_DONE;
        odata_q  <= '0;
        oslot_q  <= 2'(sum_slot_q);
        olen_q   <= 10'(t_cap);
        olast_q  <= 1'b0;
      end

      if (cmd_i.dr_pick && !dr_active_q) begin
        if (pick_any) begin
          dr_active_q <= 1'b1;
          dr_slot_q   <= pick_idx;
          dr_pos_q    <= '0;
          dr_k_q      <= '0;
          dr_off_q    <= '0;
        end else begin
          ovalid_q <= 1'b1;
          ost_q    <= cmr_pkg::ST_DRAIN_EMPTY;
          odata_q  <= '0;
          oslot_q  <= '0;
          olen_q   <= '0;
          olast_q  <= 1'b0;
        end
      end

      if (cmd_i.dr_chk && !sts_o.chk_hit) begin
        dr_k_q   <= dr_k_q + KW'(1);
        dr_off_q <= '0;
      end

      if (cmd_i.dr_test || (cmd_i.dr_byte && dr_last)) begin
        // free the drained slot
        dr_active_q        <= 1'b0;
        sref_q[dr_slot_q]  <= '0;
        stot_q[dr_slot_q]  <= '0;
        valid_q[dr_slot_q] <= '0;
        ready_q[dr_slot_q] <= 1'b0;
        if (ctx_open_q && ctx_slot_q == dr_slot_q) begin
          ctx_open_q <= 1'b0;
        end
      end

      if (cmd_i.dr_test) begin
        ovalid_q <= 1'b1;
        ost_q    <= cmr_pkg::ST_DRAIN_EMPTY;
        odata_q  <= '0;
        oslot_q  <= '0;
        olen_q   <= '0;
        olast_q  <= 1'b0;
      end

      if (cmd_i.dr_byte) begin
        dr_off_q <= dr_off_q + CW'(1);
        dr_pos_q <= pos_nx;
        ovalid_q <= 1'b1;
        ost_q    <= cmr_pkg::ST_DRAIN_BYTE;
        odata_q  <= byte_rd_q;
        oslot_q  <= 2'(dr_slot_q);
        olen_q   <= 10'(t_cur);
        olast_q  <= dr_last;
      end
    end
  end

  assign out_valid_o    = ovalid_q;
  assign status_o       = ost_q;
  assign data_out_o     = odata_q;
  assign slot_o         = oslot_q;
  assign total_length_o = olen_q;
  assign drain_last_o   = olast_q;

endmodule

FILE: rtl/concat_message_reassembly.sv
// ----------------------------------------------------------------------------
// concat_message_reassembly
// Reassembles multi-part messages from segment bytes and drains them.
// ----------------------------------------------------------------------------
// Segment: an accepted word is latched, then executed in EXEC once the
//   output register is free; the byte that completes a message also runs
//   the length sum, which reads one segment length at a time through the
//   length store port (SUM_RD, then SUM_ACC) before SUM_FIN loads the result.
// Drain: an accepted word passes EXEC, DR_TEST and DR_CHK before DR_BYTE
//   loads the byte, with DR_TEST and DR_CHK again for each segment boundary
//   stepped over; a drain with no ready slot answers from EXEC.
// Throughput: one word in flight; the next word is taken as soon as the
//   sequencer is idle, even while a result waits in the output register.
// Reset: slot tables, segment context and drain pointer clear at once; the
//   length and byte stores are not cleared (no clearing pass).
// ----------------------------------------------------------------------------
module concat_message_reassembly #(
  parameter int unsigned SLOTS     = cmr_pkg::SLOTS_DEF,
  parameter int unsigned MAX_SEGS  = cmr_pkg::MAX_SEGS_DEF,
  parameter int unsigned SEG_BYTES = cmr_pkg::SEG_BYTES_DEF,
  parameter int unsigned MSG_CAP   = cmr_pkg::MSG_CAP_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        op_i,
  input  logic [15:0] msg_ref_i,
  input  logic [7:0]  msg_total_i,
  input  logic [7:0]  seg_number_i,
  input  logic [7:0]  data_in_i,
  input  logic        seg_last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [7:0]  data_out_o,
  output logic [1:0]  slot_o,
  output logic [9:0]  total_length_o,
  output logic        drain_last_o
);

  cmr_pkg::cmd_t cmd;
  cmr_pkg::sts_t sts;

  // Sequencer: one word at a time through segment, sum or drain steps
  cmr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Tables, stores, drain pointer and the result register
  cmr_dpath #(
    .SLOTS     (SLOTS),
    .MAX_SEGS  (MAX_SEGS),
    .SEG_BYTES (SEG_BYTES),
    .MSG_CAP   (MSG_CAP)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .op_i           (op_i),
    .msg_ref_i      (msg_ref_i),
    .msg_total_i    (msg_total_i),
    .seg_number_i   (seg_number_i),
    .data_in_i      (data_in_i),
    .seg_last_i     (seg_last_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .data_out_o     (data_out_o),
    .slot_o         (slot_o),
    .total_length_o (total_length_o),
    .drain_last_o   (drain_last_o)
  );

  // Never load a result over one that has not been taken
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.seg_go || cmd.sum_fin || cmd.dr_test || cmd.dr_byte || cmd.dr_pick)
      |-> sts.out_free)
    else $error("result loaded while output register busy");

  // No work step while a new word is being taken
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !(cmd.seg_go || cmd.sum_acc || cmd.dr_chk || cmd.dr_byte))
    else $error("work step while idle");

  // Length sum alternates read and accumulate
  a_sum_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.sum_acc |-> $past(cmd.sum_rd))
    else $error("accumulate without a preceding read");

endmodule

FILE: tb/sv/reassembly_checker.sv
// ----------------------------------------------------------------------------
// reassembly_checker
// Watches both channels of the message reassembly block, predicts each
// result from its own copy of the slot tables and stores, compares results.
// ----------------------------------------------------------------------------
module reassembly_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic        op_i,
  input  logic [15:0] msg_ref_i,
  input  logic [7:0]  msg_total_i,
  input  logic [7:0]  seg_number_i,
  input  logic [7:0]  data_in_i,
  input  logic        seg_last_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [2:0]  status_i,
  input  logic [7:0]  data_out_i,
  input  logic [1:0]  slot_i,
  input  logic [9:0]  total_length_i,
  input  logic        drain_last_i,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NSLOT = cmr_pkg::SLOTS_DEF;
  localparam int unsigned NSEG  = cmr_pkg::MAX_SEGS_DEF;
  localparam int unsigned SEGB  = cmr_pkg::SEG_BYTES_DEF;
  localparam int unsigned CAP   = cmr_pkg::MSG_CAP_DEF;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] data;
    logic [1:0] slot;
    logic [9:0] tlen;
    logic       last;
  } reasm_result_t;

  reasm_result_t result_q[$];

  logic [15:0]     slot_ref[NSLOT];
  logic [7:0]      slot_tot[NSLOT];
  bit [NSEG-1:0]   seg_ok[NSLOT];
  bit              slot_full[NSLOT];
  int unsigned     seg_len[NSLOT*NSEG];
  logic [7:0]      seg_mem[NSLOT*NSEG*SEGB];
  bit              seg_open, seg_long;
  int unsigned     seg_slot, seg_idx, seg_cnt;
  bit              dr_active;
  int unsigned     dr_slot, dr_pos;
  int              fails;

  function automatic int unsigned message_len(int unsigned s);
    int unsigned sum, n;
    sum = 0;
    n = (32'(slot_tot[s]) > NSEG) ? NSEG : 32'(slot_tot[s]);
    for (int unsigned k = 0; k < n; k++) sum += seg_len[s*NSEG + k];
    return (sum >= CAP) ? CAP - 1 : sum;
  endfunction

  task automatic clear_slot(int unsigned s);
    slot_ref[s] = '0;
    slot_tot[s] = '0;
    slot_full[s] = 0;
    seg_ok[s] = '0;
    if (seg_open && seg_slot == s) seg_open = 0;
  endtask

  task automatic predict_drain(output reasm_result_t e);
    int s;
    int unsigned t, p, k;
    e = '0;
    e.status = cmr_pkg::ST_DRAIN_EMPTY;
    if (!dr_active) begin
      s = -1;
      for (int i = 0; i < NSLOT; i++) if (s < 0 && slot_full[i]) s = i;
      if (s >= 0) begin
        dr_active = 1;
        dr_slot = unsigned'(s);
        dr_pos = 0;
      end
    end
    if (dr_active) begin
      t = message_len(dr_slot);
      if (dr_pos >= t) begin
        clear_slot(dr_slot);
        dr_active = 0;
      end else begin
        // walk the segments to find the byte at this position
        p = dr_pos;
        k = 0;
        while (k < NSEG - 1 && p >= seg_len[dr_slot*NSEG + k]) begin
          p -= seg_len[dr_slot*NSEG + k];
          k++;
        end
        e.status = cmr_pkg::ST_DRAIN_BYTE;
        e.data = seg_mem[(dr_slot*NSEG + k)*SEGB + p];
        e.slot = 2'(dr_slot);
        e.tlen = 10'(t);
        dr_pos++;
        if (dr_pos >= t) begin
          e.last = 1;
          clear_slot(dr_slot);
          dr_active = 0;
        end
      end
    end
  endtask

  task automatic predict_segment(input logic [15:0] r, input logic [7:0] tot,
                                 input logic [7:0] sn, input logic [7:0] d,
                                 input logic lst, output reasm_result_t e);
    int s;
    int unsigned k;
    bit all_ok;
    e = '0;
    e.status = cmr_pkg::ST_PASS;
    e.data = d;
    if (tot == 0 || 32'(tot) > NSEG || sn == 0 || sn > tot) return;
    s = -1;
    for (int i = 0; i < NSLOT; i++)
      if (s < 0 && slot_tot[i] != 0 && slot_ref[i] == r && slot_tot[i] == tot) s = i;
    if (s < 0) begin
      for (int i = 0; i < NSLOT; i++) if (s < 0 && slot_tot[i] == 0) s = i;
      if (s < 0) return;
      slot_ref[s] = r;
      slot_tot[s] = tot;
      seg_ok[s] = '0;
      slot_full[s] = 0;
    end
    if (slot_full[s]) return;
    k = 32'(sn) - 32'd1;
    if (!(seg_open && seg_slot == unsigned'(s) && seg_idx == k)) begin
      seg_open = 1;
      seg_slot = unsigned'(s);
      seg_idx = k;
      seg_cnt = 0;
      seg_long = 0;
      seg_ok[s][k] = 0;
    end
    if (seg_cnt < SEGB) begin
      seg_mem[(unsigned'(s)*NSEG + k)*SEGB + seg_cnt] = d;
      seg_cnt++;
    end else begin
      seg_long = 1;
    end
    e.slot = 2'(s);
    e.data = seg_long ? d : '0;
    e.status = seg_long ? cmr_pkg::ST_SEG_LONG : cmr_pkg::ST_STORED;
    if (!lst) return;
    seg_open = 0;
    if (seg_long) return;
    seg_len[unsigned'(s)*NSEG + k] = seg_cnt;
    seg_ok[s][k] = 1;
    all_ok = 1;
    for (int i = 0; i < tot; i++) if (!seg_ok[s][i]) all_ok = 0;
    if (!all_ok) begin
      e.status = cmr_pkg::ST_SEG_DONE;
      return;
    end
    slot_full[s] = 1;
    e.status = cmr_pkg::ST_MSG_DONE;
    e.tlen = 10'(message_len(unsigned'(s)));
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    fails++;
  endtask

  initial begin
    fails = 0;
    seg_open = 0;
    dr_active = 0;
    for (int unsigned i = 0; i < NSLOT; i++) clear_slot(i);
  end

  always @(posedge clk_i) begin
    reasm_result_t w;
    reasm_result_t e;
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        if (result_q.size() == 0) begin
          report_mismatch("unexpected word, status", int'(status_i), -1);
        end else begin
          w = result_q.pop_front();
          if (status_i !== w.status)
            report_mismatch("status", int'(status_i), int'(w.status));
          if (data_out_i !== w.data)
            report_mismatch("data_out", int'(data_out_i), int'(w.data));
          if (slot_i !== w.slot) report_mismatch("slot", int'(slot_i), int'(w.slot));
          if (total_length_i !== w.tlen)
            report_mismatch("total_length", int'(total_length_i), int'(w.tlen));
          if (drain_last_i !== w.last)
            report_mismatch("drain_last", int'(drain_last_i), int'(w.last));
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (op_i) predict_drain(e);
        else predict_segment(msg_ref_i, msg_total_i, seg_number_i, data_in_i, seg_last_i, e);
        result_q.push_back(e);
      end
    end
    pending_o <= result_q.size();
    fail_count_o <= fails;
  end

endmodule

FILE: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives segment and drain words into the reassembly block with random
// gaps and output stalls; the checker beside it predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 3_000_000;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        in_valid_i = 0;
  logic        in_ready_o;
  logic        op_i = 0;
  logic [15:0] msg_ref_i = '0;
  logic [7:0]  msg_total_i = '0;
  logic [7:0]  seg_number_i = '0;
  logic [7:0]  data_in_i = '0;
  logic        seg_last_i = 0;
  logic        out_valid_o;
  logic        out_ready_i = 0;
  logic [2:0]  status_o;
  logic [7:0]  data_out_o;
  logic [1:0]  slot_o;
  logic [9:0]  total_length_o;
  logic        drain_last_o;

  int          fail_count;
  int          pending;
  int unsigned words_taken, results_taken, cycles, items;
  bit          burst;  // no idling on either side while set

  concat_message_reassembly u_dut (.*);

  reassembly_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_i(in_ready_o),
    .op_i, .msg_ref_i, .msg_total_i, .seg_number_i, .data_in_i, .seg_last_i,
    .out_valid_i(out_valid_o), .out_ready_i,
    .status_i(status_o), .data_out_i(data_out_o), .slot_i(slot_o),
    .total_length_i(total_length_o), .drain_last_i(drain_last_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Count handshakes at the rising edge; drivers look at them on the falling edge.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      words_taken <= 0;
      results_taken <= 0;
    end else begin
      if (in_valid_i && in_ready_o) words_taken <= words_taken + 1;
      if (out_valid_o && out_ready_i) results_taken <= results_taken + 1;
    end
  end

  // Watchdog: end the run if it hangs.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("testbench NOT OK");
        $finish;
      end
    end
  end

  // Result side: stall a random number of cycles before each word.
  initial begin
    int unsigned stall, seen;
    wait (rst_ni);
    @(negedge clk_i);
    forever begin
      stall = burst ? 0 : $urandom_range(0, 16);
      if (stall > 0) begin
        out_ready_i <= 0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1;
      seen = results_taken;
      do @(negedge clk_i); while (results_taken == seen);
    end
  end

  // Present one word and hold it until taken. Lower valid only for a gap,
  // so back-to-back words keep valid high.
  task automatic send_word(logic op, logic [15:0] r, logic [7:0] tot, logic [7:0] sn,
                           logic [7:0] d, logic lst);
    int unsigned gap, seen;
    gap = burst ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid_i <= 0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1;
    op_i <= op;
    msg_ref_i <= r;
    msg_total_i <= tot;
    seg_number_i <= sn;
    data_in_i <= d;
    seg_last_i <= lst;
    seen = words_taken;
    do @(negedge clk_i); while (words_taken == seen);
    items++;
  endtask

  task automatic send_segment(logic [15:0] r, logic [7:0] tot, logic [7:0] sn, int len);
    for (int i = 0; i < len; i++)
      send_word(1'b0, r, tot, sn, 8'($urandom_range(0, 255)), i == len - 1);
  endtask

  task automatic drain_words(int n);
    repeat (n) send_word(1'b1, 16'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                         1'($urandom_range(0, 1)));
  endtask

  // Hold the sender until every expected result is back.
  task automatic wait_idle();
    in_valid_i <= 0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Send every segment of one message in shuffled order; sometimes repeat
  // a segment or abandon one halfway first.
  task automatic send_message(logic [15:0] r, int tot, int maxlen);
    int order[$];
    int j, tmp, total_bytes;
    for (int i = 1; i <= tot; i++) order.push_back(i);
    for (int i = tot - 1; i > 0; i--) begin
      j = int'($urandom_range(0, i));
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    total_bytes = 0;
    foreach (order[i]) begin
      if ($urandom_range(0, 7) == 0)
        send_word(1'b0, r, 8'(tot), 8'(order[i]), 8'($urandom), 1'b0);
      if ($urandom_range(0, 9) == 0)
        send_segment(r, 8'(tot), 8'(order[i]), int'($urandom_range(1, maxlen)));
      tmp = int'($urandom_range(1, maxlen));
      total_bytes += tmp;
      send_segment(r, 8'(tot), 8'(order[i]), tmp);
    end
    // poke the finished slot before it is drained
    if ($urandom_range(0, 5) == 0)
      send_word(1'b0, r, 8'(tot), 8'd1, 8'($urandom), 1'($urandom_range(0, 1)));
    if ($urandom_range(0, 1) == 0) drain_words(int'($urandom_range(1, total_bytes + 2)));
  endtask

  // Header that the block must refuse.
  task automatic send_bad_header();
    logic [7:0] tot, sn;
    case ($urandom_range(0, 3))
      0: begin tot = 8'd0; sn = 8'($urandom); end
      1: begin tot = 8'($urandom_range(9, 255)); sn = 8'($urandom); end
      2: begin tot = 8'($urandom_range(1, 8)); sn = 8'd0; end
      default: begin
        tot = 8'($urandom_range(1, 254));
        sn = 8'($urandom_range(32'(tot) + 1, 255));
      end
    endcase
    send_word(1'b0, 16'($urandom), tot, sn, 8'($urandom), 1'($urandom_range(0, 1)));
  endtask

  initial begin
    logic [15:0] pool[4];
    int idx;
    items = 0;
    burst = 0;
    pool = '{16'h1111, 16'h2222, 16'hEEEE, 16'h0000};
    repeat (6) @(negedge clk_i);
    rst_ni = 1;
    repeat (2) @(negedge clk_i);

    // directed: refused headers, empty drain, small complete messages
    send_word(1'b0, 16'h0001, 8'd0, 8'd1, 8'hFF, 1'b1);
    send_word(1'b0, 16'h0001, 8'd9, 8'd1, 8'h00, 1'b1);
    send_word(1'b0, 16'h0001, 8'd2, 8'd0, 8'hA5, 1'b0);
    send_word(1'b0, 16'hFFFF, 8'd255, 8'd255, 8'h5A, 1'b1);
    send_word(1'b0, 16'h0001, 8'd3, 8'd4, 8'h81, 1'b1);
    drain_words(1);
    send_word(1'b0, 16'h0000, 8'd1, 8'd1, 8'h00, 1'b0);
    send_word(1'b0, 16'h0000, 8'd1, 8'd1, 8'hFF, 1'b1);
    send_word(1'b0, 16'h0000, 8'd1, 8'd1, 8'h33, 1'b1);  // slot already complete
    drain_words(3);
    send_word(1'b0, 16'hFFFF, 8'd8, 8'd8, 8'hFF, 1'b1);
    send_word(1'b0, 16'hFFFF, 8'd8, 8'd3, 8'h11, 1'b0);
    send_word(1'b0, 16'hFFFF, 8'd8, 8'd5, 8'h22, 1'b1);  // switch abandons segment 3 unfinished
    for (int s = 1; s <= 7; s++) send_segment(16'hFFFF, 8'd8, 8'(s), 1);
    drain_words(9);
    wait_idle();

    // every slot claimed, then one message too many
    for (int i = 0; i < 4; i++) send_segment(16'h4000 + 16'(i), 8'd2, 8'd1, 2);
    send_word(1'b0, 16'h5000, 8'd1, 8'd1, 8'h77, 1'b1);
    for (int i = 0; i < 4; i++) send_segment(16'h4000 + 16'(i), 8'd2, 8'd2, 1);
    drain_words(14);
    wait_idle();

    // over-long segment back to back, then the same message done properly
    burst = 1;
    send_segment(16'hA5A5, 8'd1, 8'd1, 515);
    burst = 0;
    send_segment(16'hA5A5, 8'd1, 8'd1, 3);
    drain_words(4);
    wait_idle();

    while (items < 700) begin
      if ($urandom_range(0, 40) == 0) burst = ~burst;
      case ($urandom_range(0, 11))
        0, 1, 2, 3: send_message(16'($urandom), int'($urandom_range(1, 3)), 6);
        4: send_message(16'($urandom), int'($urandom_range(4, 8)), 4);
        5: begin
          idx = int'($urandom_range(0, 3));
          send_message(pool[idx], idx + 2, 5);
        end
        6: begin
          idx = int'($urandom_range(0, 3));
          send_segment(pool[idx], 8'(idx + 2), 8'($urandom_range(1, idx + 2)),
                       int'($urandom_range(1, 4)));
        end
        7: send_bad_header();
        8, 9: drain_words(int'($urandom_range(1, 30)));
        10: wait_idle();
        default: send_word(1'b1, 16'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                           1'($urandom_range(0, 1)));
      endcase
    end
    // finish off the pool messages so they drain too
    for (int i = 0; i < 4; i++) send_message(pool[i], i + 2, 3);
    drain_words(150);

    if (in_valid_i) in_valid_i <= 0;
    while (pending != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
